/* rtl/core/websocket_frame_deframer_assert.svh */
// Assertion macros for the WebSocket deframer core.
// No dependencies; included by websocket_frame_deframer, the only module that checks itself.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* rtl/core/wsd_pkg.sv */
// Shared types and constants for the WebSocket deframer.
// No dependencies; used by the parser and the top level.
`default_nettype none

package wsd_pkg;

    localparam logic [6:0] LEN_ESC16      = 7'd126;
    localparam logic [6:0] LEN_ESC64      = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

    // One parse result, valid for the byte taken in the same cycle.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
        logic       empty;
    } wsd_result_t;

endpackage

`default_nettype wire

/* rtl/core/wsd_if.sv */
// Stream interfaces for the WebSocket deframer: raw bytes in, payload out.
// No dependencies.
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_end;
    logic       empty_frame;

    modport source (output valid, output payload_byte, output frame_opcode,
                    output frame_end, output empty_frame, input ready);
    modport sink   (input valid, input payload_byte, input frame_opcode,
                    input frame_end, input empty_frame, output ready);
endinterface

`default_nettype wire

/* rtl/core/wsd_parser.sv */
// Frame header parser and payload unmasker, one byte per transaction.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          stream_byte,
    output      wsd_pkg::wsd_result_t res
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [2:0]  mask_left_reg, mask_left_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] pl_left_reg, pl_left_next;
    logic [1:0]  index_reg, index_next;

    logic [6:0]  len7;
    logic [63:0] pl_shift;
    logic        len_done;
    logic [63:0] len_val;
    logic        hdr_done;
    logic [7:0]  key_byte;

    assign len7     = stream_byte[6:0];
    assign pl_shift = {pl_left_reg[55:0], stream_byte};

    always_comb
    begin
        unique case (index_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
            default: key_byte = key_reg[31:24];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        ext_left_next  = ext_left_reg;
        mask_left_next = mask_left_reg;
        key_next       = key_reg;
        pl_left_next   = pl_left_reg;
        index_next     = index_reg;
        len_done       = 1'b0;
        len_val        = 64'd0;
        hdr_done       = 1'b0;
        res            = '0;
        res.opcode     = opcode_reg;

        if (take)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    masked_next  = stream_byte[7];
                    pl_left_next = 64'd0;
                    if (len7 == wsd_pkg::LEN_ESC16)
                    begin
                        ext_left_next = wsd_pkg::EXT16_BYTES;
                        phase_next    = PH_EXTLEN;
                    end
                    else if (len7 == wsd_pkg::LEN_ESC64)
                    begin
                        ext_left_next = wsd_pkg::EXT64_BYTES;
                        phase_next    = PH_EXTLEN;
                    end
                    else
                    begin
                        len_done = 1'b1;
                        len_val  = {57'd0, len7};
                    end
                end
                PH_EXTLEN:
                begin
                    pl_left_next  = pl_shift;
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_next == 4'd0)
                    begin
                        // top bit of the long length is dropped
                        len_done = 1'b1;
                        len_val  = {1'b0, pl_shift[62:0]};
                    end
                end
                PH_MASK:
                begin
                    key_next       = {key_reg[23:0], stream_byte};
                    mask_left_next = mask_left_reg - 3'd1;
                    if (mask_left_next == 3'd0)
                        hdr_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    res.valid    = 1'b1;
                    res.data     = masked_reg ? (stream_byte ^ key_byte) : stream_byte;
                    res.last     = (pl_left_reg == 64'd1);
                    index_next   = index_reg + 2'd1;
                    pl_left_next = pl_left_reg - 64'd1;
                    if (res.last)
                        phase_next = PH_HDR0;
                end
                default:
                begin
                    opcode_next = stream_byte[3:0];
                    phase_next  = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                pl_left_next = len_val;
                if (masked_next)
                begin
                    mask_left_next = wsd_pkg::MASK_KEY_BYTES;
                    key_next       = 32'd0;
                    phase_next     = PH_MASK;
                end
                else
                    hdr_done = 1'b1;
            end

            if (hdr_done)
            begin
                if (pl_left_next == 64'd0)
                begin
                    // zero-length frame: one marker transaction
                    res.valid  = 1'b1;
                    res.data   = 8'd0;
                    res.last   = 1'b1;
                    res.empty  = 1'b1;
                    phase_next = PH_HDR0;
                end
                else
                begin
                    index_next = 2'd0;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            opcode_reg    <= 4'd0;
            masked_reg    <= 1'b0;
            ext_left_reg  <= 4'd0;
            mask_left_reg <= 3'd0;
            key_reg       <= 32'd0;
            pl_left_reg   <= 64'd0;
            index_reg     <= 2'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            masked_reg    <= masked_next;
            ext_left_reg  <= ext_left_next;
            mask_left_reg <= mask_left_next;
            key_reg       <= key_next;
            pl_left_reg   <= pl_left_next;
            index_reg     <= index_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
// WebSocket frame deframer: one raw byte in, at most one payload transaction out.
// Output: a result appears in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle; input stalls only while a held result is not taken.
// Reset: parser returns to the first header byte, all lengths and key cleared,
// output register emptied.
// Depends on wsd_pkg, wsd_if and wsd_parser.
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
    input wire logic clk,
    input wire logic rst_n,
    wsd_in_if.sink   in_ch,
    wsd_out_if.source out_ch
);

    wsd_pkg::wsd_result_t res;

    logic       take;
    logic       in_ready;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_reg;
    logic [3:0] opcode_reg;
    logic       last_reg;
    logic       empty_reg;

    // output register may be refilled in the cycle it is drained
    assign in_ready    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = in_ready;
    assign take        = in_ch.valid && in_ready;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (in_ch.stream_byte),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_ready)
            out_valid_next = take && res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            data_reg   <= res.data;
            opcode_reg <= res.opcode;
            last_reg   <= res.last;
            empty_reg  <= res.empty;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = data_reg;
    assign out_ch.frame_opcode = opcode_reg;
    assign out_ch.frame_end    = last_reg;
    assign out_ch.empty_frame  = empty_reg;

    `WSD_ASSERT_NOW(a_empty_is_end, clk, rst_n,
        out_valid_reg && empty_reg, last_reg && (data_reg == 8'd0))
    `WSD_ASSERT_NOW(a_no_take_when_held, clk, rst_n,
        out_valid_reg && !out_ch.ready, !in_ch.ready)
    `WSD_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        take && res.valid, out_valid_reg)
    `WSD_ASSERT_NEXT(a_drain_clears, clk, rst_n,
        out_valid_reg && out_ch.ready && !(take && res.valid), !out_valid_reg)

endmodule

`default_nettype wire
